@@ design/dfd_pkg.sv @@
package dfd_pkg;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_COUNTS,
        PH_BETWEEN,
        PH_PAYLOAD,
        PH_TAIL,
        PH_DISCARD
    } phase_t;

    localparam logic [7:0] BYTE_HEADER  = 8'hAA;
    localparam logic [7:0] BYTE_TRAILER = 8'hBB;
    localparam logic [7:0] BYTE_START_LO = 8'h1A;
    localparam logic [7:0] BYTE_START_HI = 8'h4A;
    localparam logic [3:0] START_NIBBLE = 4'hA;
    localparam logic [3:0] TAIL_NIBBLE  = 4'hB;

    localparam logic [2:0] KIND_OBJECT = 3'd0;
    localparam logic [2:0] KIND_ZEBRA  = 3'd1;
    localparam logic [2:0] KIND_LIGHT  = 3'd2;
    localparam logic [2:0] KIND_STAIRS = 3'd3;
    localparam logic [2:0] KIND_END    = 3'd4;

    localparam logic [1:0] ST_OK           = 2'd0;
    localparam logic [1:0] ST_TAIL_BAD     = 2'd1;
    localparam logic [1:0] ST_FRAME_BAD    = 2'd2;
    localparam logic [1:0] ST_END_IN_GROUP = 2'd3;

    localparam logic [1:0] GROUP_OBJECT = 2'd0;
    localparam logic [1:0] GROUP_ZEBRA  = 2'd1;

    localparam int PAYLOAD_MAX = 9;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       last;
    } beat_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  record_index;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [7:0]  attribute;
        logic [7:0]  distance_tenths;
        logic [7:0]  vertical;
        logic [15:0] wide_value;
        logic [1:0]  status;
    } result_t;

    function automatic logic [3:0] payload_len(input logic [1:0] group);
        logic [3:0] len;
        case (group)
            2'd0:    len = 4'd9;
            2'd1:    len = 4'd6;
            default: len = 4'd5;
        endcase
        return len;
    endfunction

endpackage

@@ design/dfd_in_stage.sv @@
module dfd_in_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic [7:0]     data_byte,
    input  logic           frame_last,
    input  logic           advance,
    output logic           in_stall,
    output dfd_pkg::beat_t beat
);
    import dfd_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] data_reg;
    logic       last_reg;
    logic       take;

    assign in_stall = valid_reg && !advance;
    assign take     = in_valid && !in_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            data_reg <= data_byte;
            last_reg <= frame_last;
        end
    end

    assign beat.valid = valid_reg;
    assign beat.data  = data_reg;
    assign beat.last  = last_reg;

endmodule

@@ design/dfd_parser.sv @@
module dfd_parser (
    input  logic             clk,
    input  logic             rst_n,
    input  dfd_pkg::beat_t   beat,
    input  logic             advance,
    output logic             has_result,
    output dfd_pkg::result_t res
);
    import dfd_pkg::*;

    phase_t     phase_reg, phase_next;
    logic [2:0] hpos_reg, hpos_next;
    logic [1:0] group_reg, group_next;
    logic [7:0] left_reg, left_next;
    logic [7:0] index_reg, index_next;
    logic [3:0] bpos_reg, bpos_next;
    logic       seen_reg, seen_next;
    logic [7:0] counts_reg [4];
    logic [7:0] counts_next [4];
    logic [7:0] store_reg [PAYLOAD_MAX];
    logic [7:0] view [PAYLOAD_MAX];
    logic [7:0] b;
    logic [1:0] start_type;
    logic [7:0] want;
    logic [3:0] plen;

    assign b          = beat.data;
    assign start_type = 2'(b[5:4] - 2'd1);
    assign want       = {1'b0, 3'({1'b0, group_reg} + 3'd1), TAIL_NIBBLE};
    assign plen       = payload_len(group_reg);

    always_comb
    begin
        for (int k = 0; k < PAYLOAD_MAX; k++)
        begin
            view[k] = (bpos_reg == 4'(k)) ? b : store_reg[k];
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        hpos_next  = hpos_reg;
        group_next = group_reg;
        left_next  = left_reg;
        index_next = index_reg;
        bpos_next  = bpos_reg;
        seen_next  = seen_reg;
        for (int k = 0; k < 4; k++)
        begin
            counts_next[k] = counts_reg[k];
        end
        has_result = 1'b0;
        res        = '0;

        if (beat.last)
        begin
            has_result = 1'b1;
            res.kind   = KIND_END;
            if (!seen_reg || phase_reg == PH_COUNTS || phase_reg == PH_HUNT
                || phase_reg == PH_DISCARD)
            begin
                res.status = ST_FRAME_BAD;
            end
            else if (phase_reg == PH_PAYLOAD || phase_reg == PH_TAIL)
            begin
                res.status = ST_END_IN_GROUP;
            end
            else if (b != BYTE_TRAILER)
            begin
                res.status = ST_FRAME_BAD;
            end
            else
            begin
                res.status = ST_OK;
            end
            phase_next = PH_HUNT;
            hpos_next  = '0;
            group_next = '0;
            left_next  = '0;
            index_next = '0;
            bpos_next  = '0;
            seen_next  = 1'b0;
            for (int k = 0; k < 4; k++)
            begin
                counts_next[k] = '0;
            end
        end
        else
        begin
            case (phase_reg)
                PH_HUNT:
                begin
                    if (b == BYTE_HEADER)
                    begin
                        seen_next  = 1'b1;
                        hpos_next  = '0;
                        phase_next = PH_COUNTS;
                    end
                    else
                    begin
                        phase_next = PH_DISCARD;
                    end
                end
                PH_COUNTS:
                begin
                    counts_next[hpos_reg[1:0]] = b;
                    hpos_next = 3'(hpos_reg + 3'd1);
                    if (hpos_next[2])
                    begin
                        phase_next = PH_BETWEEN;
                    end
                end
                PH_BETWEEN:
                begin
                    if (b[3:0] == START_NIBBLE && b >= BYTE_START_LO && b <= BYTE_START_HI
                        && counts_reg[start_type] != 8'd0)
                    begin
                        group_next = start_type;
                        left_next  = counts_reg[start_type];
                        index_next = '0;
                        bpos_next  = '0;
                        phase_next = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD:
                begin
                    bpos_next = 4'(bpos_reg + 4'd1);
                    if (bpos_next == plen)
                    begin
                        phase_next       = PH_TAIL;
                        has_result       = 1'b1;
                        res.kind         = {1'b0, group_reg};
                        res.record_index = index_reg;
                        res.pos_x        = {view[0], view[1]};
                        res.pos_y        = {view[2], view[3]};
                        if (group_reg == GROUP_OBJECT)
                        begin
                            res.attribute       = view[4];
                            res.distance_tenths = view[5];
                            res.vertical        = view[6];
                            res.wide_value      = {view[7], view[8]};
                        end
                        else if (group_reg == GROUP_ZEBRA)
                        begin
                            res.wide_value = {view[4], view[5]};
                        end
                        else
                        begin
                            res.attribute = view[4];
                        end
                    end
                end
                PH_TAIL:
                begin
                    bpos_next = '0;
                    if (b == want)
                    begin
                        left_next  = 8'(left_reg - 8'd1);
                        index_next = 8'(index_reg + 8'd1);
                        phase_next = (left_next == 8'd0) ? PH_BETWEEN : PH_PAYLOAD;
                    end
                    else
                    begin
                        has_result       = 1'b1;
                        res.kind         = {1'b0, group_reg};
                        res.record_index = index_reg;
                        res.status       = ST_TAIL_BAD;
                        left_next        = '0;
                        phase_next       = PH_BETWEEN;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            hpos_reg  <= '0;
            group_reg <= '0;
            left_reg  <= '0;
            index_reg <= '0;
            bpos_reg  <= '0;
            seen_reg  <= 1'b0;
            for (int k = 0; k < 4; k++)
            begin
                counts_reg[k] <= '0;
            end
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            hpos_reg  <= hpos_next;
            group_reg <= group_next;
            left_reg  <= left_next;
            index_reg <= index_next;
            bpos_reg  <= bpos_next;
            seen_reg  <= seen_next;
            for (int k = 0; k < 4; k++)
            begin
                counts_reg[k] <= counts_next[k];
            end
        end
    end

    // Payload bytes land in the slot named by the byte position.
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < PAYLOAD_MAX; k++)
        begin
            if (advance && !beat.last && phase_reg == PH_PAYLOAD && bpos_reg == 4'(k))
            begin
                store_reg[k] <= b;
            end
        end
    end

    a_payload_pos: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_PAYLOAD |-> bpos_reg < plen)
        else $error("payload byte position past record length");

    a_tail_pos: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_TAIL |-> bpos_reg == plen)
        else $error("tail reached before record complete");

    a_counts_pos: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_COUNTS |-> !hpos_reg[2] && seen_reg)
        else $error("header count position out of range");

endmodule

@@ design/dfd_out_stage.sv @@
module dfd_out_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  dfd_pkg::result_t res,
    input  logic             out_stall,
    output logic             out_valid,
    output dfd_pkg::result_t held
);
    import dfd_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign held      = res_reg;

endmodule

@@ design/detection_frame_deframer.sv @@
// A byte accepted into the input register yields its result through the result register, which drives out_valid.
// Throughput: one byte per cycle while out_stall is not holding a result, set by the input and result register pair.
// A byte that causes no result still passes through the input register, and waits there while out_stall holds a result.
// Reset is asynchronous and active low; it returns the parser to header hunting.
// Payload bytes are not cleared by reset.
module detection_frame_deframer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        frame_last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  kind,
    output logic [7:0]  record_index,
    output logic [15:0] pos_x,
    output logic [15:0] pos_y,
    output logic [7:0]  attribute,
    output logic [7:0]  distance_tenths,
    output logic [7:0]  vertical,
    output logic [15:0] wide_value,
    output logic [1:0]  status
);
    import dfd_pkg::*;

    beat_t   beat;
    result_t res;
    result_t held;
    logic    has_result;
    logic    advance;

    // The input register drains whenever the result register can take a new beat.
    assign advance = beat.valid && (!out_valid || !out_stall);

    dfd_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .data_byte  (data_byte),
        .frame_last (frame_last),
        .advance    (advance),
        .in_stall   (in_stall),
        .beat       (beat)
    );

    dfd_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .beat       (beat),
        .advance    (advance),
        .has_result (has_result),
        .res        (res)
    );

    dfd_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance && has_result),
        .res       (res),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .held      (held)
    );

    assign kind            = held.kind;
    assign record_index    = held.record_index;
    assign pos_x           = held.pos_x;
    assign pos_y           = held.pos_y;
    assign attribute       = held.attribute;
    assign distance_tenths = held.distance_tenths;
    assign vertical        = held.vertical;
    assign wide_value      = held.wide_value;
    assign status          = held.status;

    a_end_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_END |-> record_index == 8'd0 && pos_x == 16'd0
            && pos_y == 16'd0 && wide_value == 16'd0)
        else $error("frame end beat carries record data");

    a_tail_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_TAIL_BAD |-> kind != KIND_END && pos_x == 16'd0)
        else $error("tail mismatch beat malformed");

    a_group_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_END_IN_GROUP || status == ST_FRAME_BAD) |-> kind == KIND_END)
        else $error("frame status on a record beat");

endmodule
